// ===== rtl/core/mlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared constants, operation codes and types for the monochrome page
// frame buffer pixel engine.
// ----------------------------------------------------------------------------
package mlcd_pkg;

    localparam int PANEL_WIDTH  = 84;
    localparam int PANEL_HEIGHT = 48;
    localparam int PAGE_BITS    = 8;
    localparam int PAGE_ROWS    = (PANEL_HEIGHT + PAGE_BITS - 1) / PAGE_BITS;
    localparam int STORE_DEPTH  = PANEL_WIDTH * PAGE_ROWS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 9;
    localparam int PIX_W   = 8;
    localparam int BIT_W   = $clog2(PAGE_BITS);
    // holds PANEL_WIDTH * (page) + column for any in-range point
    localparam int IDX_W   = 16;

    localparam logic [1:0] FUNC_DRAW = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] COLOUR_CLEAR  = 2'd0;
    localparam logic [1:0] COLOUR_SET    = 2'd1;
    localparam logic [1:0] COLOUR_TOGGLE = 2'd2;

    // mapped draw point
    typedef struct packed {
        logic              clip;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [BIT_W-1:0]  bit_sel;
    } mlcd_point_t;

    // request to the frame store
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mlcd_mem_req_t;

endpackage

// ===== rtl/core/mlcd_map.sv =====
// ----------------------------------------------------------------------------
// mlcd_map
// Clips a signed point against the rotated panel and maps it to a store
// byte address and a bit within that byte.
// ----------------------------------------------------------------------------
module mlcd_map
(
    input  logic signed [mlcd_pkg::COORD_W-1:0] x_coord,
    input  logic signed [mlcd_pkg::COORD_W-1:0] y_coord,
    input  logic [1:0]                          rotation,
    output mlcd_pkg::mlcd_point_t               point
);
    import mlcd_pkg::*;

    logic signed [COORD_W:0] xs;
    logic signed [COORD_W:0] ys;
    logic signed [COORD_W:0] lim_w;
    logic signed [COORD_W:0] lim_h;
    logic [PIX_W-1:0]        ux;
    logic [PIX_W-1:0]        uy;
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic [IDX_W-1:0]        idx;

    assign xs = {x_coord[COORD_W-1], x_coord};
    assign ys = {y_coord[COORD_W-1], y_coord};

    // odd quarter turns swap the panel sides
    assign lim_w = rotation[0] ? (COORD_W+1)'(PANEL_HEIGHT) : (COORD_W+1)'(PANEL_WIDTH);
    assign lim_h = rotation[0] ? (COORD_W+1)'(PANEL_WIDTH)  : (COORD_W+1)'(PANEL_HEIGHT);

    assign ux = xs[PIX_W-1:0];
    assign uy = ys[PIX_W-1:0];

    always_comb
    begin
        unique case (rotation)
            2'd1:
            begin
                px = uy;
                py = PIX_W'(PANEL_HEIGHT - 1) - ux;
            end
            2'd2:
            begin
                px = PIX_W'(PANEL_WIDTH - 1) - ux;
                py = PIX_W'(PANEL_HEIGHT - 1) - uy;
            end
            2'd3:
            begin
                px = PIX_W'(PANEL_WIDTH - 1) - uy;
                py = ux;
            end
            default:
            begin
                px = ux;
                py = uy;
            end
        endcase
    end

    assign idx = IDX_W'(PANEL_WIDTH) * IDX_W'(py >> BIT_W) + IDX_W'(px);

    assign point.clip    = (xs < 0) || (xs >= lim_w) || (ys < 0) || (ys >= lim_h);
    assign point.hit     = idx < IDX_W'(STORE_DEPTH);
    assign point.addr    = idx[ADDR_W-1:0];
    assign point.bit_sel = py[BIT_W-1:0];

endmodule

// ===== rtl/core/mlcd_ram.sv =====
// ----------------------------------------------------------------------------
// mlcd_ram
// Frame store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mlcd_ram
(
    input  logic                          clk,
    input  mlcd_pkg::mlcd_mem_req_t       req,
    output logic [mlcd_pkg::BYTE_W-1:0]   rd_data
);
    import mlcd_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== rtl/core/mono_lcd_framebuffer_pixel_engine.sv =====
// ----------------------------------------------------------------------------
// mono_lcd_framebuffer_pixel_engine
// Page-organized monochrome frame buffer with draw, fill and read requests.
//
// Channel   Signals                                         Handshake
// request   func x_coord y_coord colour fill_pattern        start & !busy
//           read_index
// result    read_byte clipped                               done, one cycle
// config    rotation                                        cfg_valid & cfg_ready
//
// Draw, read and no-op requests pass through ST_OP: the store is read at the
// accept edge and, for a draw, the modified byte is written back in the next cycle.
// Fill writes fill_pattern to every store entry, one store entry per cycle.
// After reset the store is swept to zero with busy high; configuration
// writes are taken meanwhile.
// done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module mono_lcd_framebuffer_pixel_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic signed [mlcd_pkg::COORD_W-1:0] x_coord,
    input  logic signed [mlcd_pkg::COORD_W-1:0] y_coord,
    input  logic [1:0]                          colour,
    input  logic [mlcd_pkg::BYTE_W-1:0]         fill_pattern,
    input  logic [8:0]                          read_index,
    output logic                                done,
    output logic [mlcd_pkg::BYTE_W-1:0]         read_byte,
    output logic                                clipped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          rotation
);
    import mlcd_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_OP    = 2'd2;
    localparam logic [1:0] ST_FILL  = 2'd3;

    logic [1:0]        state_reg,     state_next;
    logic [ADDR_W-1:0] cnt_reg,       cnt_next;
    logic [1:0]        rotation_reg,  rotation_next;
    logic [1:0]        op_reg,        op_next;
    logic [1:0]        colour_reg,    colour_next;
    mlcd_point_t       point_reg,     point_next;
    logic              rd_ok_reg,     rd_ok_next;
    logic [BYTE_W-1:0] pattern_reg,   pattern_next;
    logic              done_reg,      done_next;
    logic [BYTE_W-1:0] read_byte_reg, read_byte_next;
    logic              clipped_reg,   clipped_next;

    mlcd_point_t       point;
    mlcd_mem_req_t     mem_req;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] new_byte;
    logic              accept;
    logic              idx_in_range;
    logic              last;

    mlcd_map u_map
    (
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .rotation (rotation_reg),
        .point    (point)
    );

    mlcd_ram u_ram
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign read_byte = read_byte_reg;
    assign clipped   = clipped_reg;

    assign idx_in_range = 32'(read_index) < STORE_DEPTH;
    assign last         = cnt_reg == ADDR_W'(STORE_DEPTH - 1);
    assign mask         = BYTE_W'(1) << point_reg.bit_sel;

    always_comb
    begin
        case (colour_reg)
            COLOUR_CLEAR:  new_byte = rd_data & ~mask;
            COLOUR_SET:    new_byte = rd_data | mask;
            COLOUR_TOGGLE: new_byte = rd_data ^ mask;
            default:       new_byte = rd_data;
        endcase
    end

    // store access: read at accept, write back in ST_OP, sweep in fill/clear
    always_comb
    begin
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = point.addr;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = point_reg.addr;
        mem_req.wr_data = new_byte;
        if (accept && func == FUNC_DRAW)
        begin
            mem_req.rd_en = !point.clip && point.hit;
        end
        else if (accept && func == FUNC_READ)
        begin
            mem_req.rd_en   = idx_in_range;
            mem_req.rd_addr = ADDR_W'(read_index);
        end
        if (state_reg == ST_OP)
        begin
            mem_req.wr_en = (op_reg == FUNC_DRAW) && !point_reg.clip && point_reg.hit;
        end
        else if (state_reg == ST_FILL || state_reg == ST_CLEAR)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_reg;
            mem_req.wr_data = (state_reg == ST_FILL) ? pattern_reg : '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rotation_next  = (cfg_valid && cfg_ready) ? rotation : rotation_reg;
        op_next        = op_reg;
        colour_next    = colour_reg;
        point_next     = point_reg;
        rd_ok_next     = rd_ok_reg;
        pattern_next   = pattern_reg;
        done_next      = 1'b0;
        read_byte_next = '0;
        clipped_next   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = func;
                    colour_next  = colour;
                    point_next   = point;
                    rd_ok_next   = idx_in_range;
                    pattern_next = fill_pattern;
                    cnt_next     = '0;
                    state_next   = (func == FUNC_FILL) ? ST_FILL : ST_OP;
                end
            end
            ST_OP:
            begin
                done_next      = 1'b1;
                read_byte_next = (op_reg == FUNC_READ && rd_ok_reg) ? rd_data : '0;
                clipped_next   = (op_reg == FUNC_DRAW) && point_reg.clip;
                state_next     = ST_IDLE;
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (last)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            rotation_reg <= '0;
            done_reg     <= 1'b0;
            pattern_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rotation_reg <= rotation_next;
            done_reg     <= done_next;
            pattern_reg  <= pattern_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        colour_reg    <= colour_next;
        point_reg     <= point_next;
        rd_ok_reg     <= rd_ok_next;
        read_byte_reg <= read_byte_next;
        clipped_reg   <= clipped_next;
    end

    // a result only follows a request in flight
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_OP || $past(state_reg) == ST_FILL))
        else $error("done without a request in flight");

    // an accepted request holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy low after accept");

    // only a read returns a nonzero byte
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_byte != '0) |-> op_reg == FUNC_READ)
        else $error("read_byte set for a non-read request");

    // clipped is part of a result
    a_clip_done: assert property (@(posedge clk) disable iff (!rst_n)
        clipped |-> done && op_reg == FUNC_DRAW)
        else $error("clipped outside a draw result");

    // write back in ST_OP belongs to a draw
    a_wb_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OP && mem_req.wr_en) |-> op_reg == FUNC_DRAW)
        else $error("store write by a non-draw request");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the monochrome page frame buffer pixel engine.
// Directed requests cover the panel corners, clipping, colours, fill, no-op
// and reads past the store. Random draw, fill and read traffic then runs
// under every rotation. Each result is checked against an in-bench model of
// the frame buffer.
// ----------------------------------------------------------------------------
module tb_top;
    import mlcd_pkg::*;

    localparam logic [1:0] FUNC_NOP          = 2'd3;
    localparam logic [1:0] COLOUR_KEEP       = 2'd3;
    localparam logic [1:0] ROT_NONE          = 2'd0;
    localparam logic [1:0] ROT_QUARTER       = 2'd1;
    localparam logic [1:0] ROT_HALF          = 2'd2;
    localparam logic [1:0] ROT_THREE_QUARTER = 2'd3;

    localparam int CYCLE_LIMIT     = 4000000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 250;

    typedef struct {
        logic [BYTE_W-1:0] rd_byte;
        logic              clip;
        int                seq;
    } engine_result_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic [1:0]                func         = FUNC_NOP;
    logic signed [COORD_W-1:0] x_coord      = '0;
    logic signed [COORD_W-1:0] y_coord      = '0;
    logic [1:0]                colour       = COLOUR_KEEP;
    logic [BYTE_W-1:0]         fill_pattern = '0;
    logic [8:0]                read_index   = '0;
    logic                      cfg_valid    = 1'b0;
    logic [1:0]                rotation     = ROT_NONE;
    logic                      busy;
    logic                      done;
    logic [BYTE_W-1:0]         read_byte;
    logic                      clipped;
    logic                      cfg_ready;

    // shadow of the frame buffer and the rotation register
    logic [BYTE_W-1:0] pix_bytes [STORE_DEPTH] = '{default: '0};
    logic [1:0]        turns_cfg = ROT_NONE;
    int                last_drawn = 0;

    engine_result_t pending_results [$];
    int             err_count   = 0;
    int             req_count   = 0;
    int             cycle_count = 0;
    bit             steady_sender = 1'b0;

    mono_lcd_framebuffer_pixel_engine u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .colour       (colour),
        .fill_pattern (fill_pattern),
        .read_index   (read_index),
        .done         (done),
        .read_byte    (read_byte),
        .clipped      (clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .rotation     (rotation)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Apply one request to the shadow buffer and return the result it gives.
    function automatic engine_result_t apply_request(
        input logic [1:0]                op,
        input logic signed [COORD_W-1:0] xv,
        input logic signed [COORD_W-1:0] yv,
        input logic [1:0]                col,
        input logic [BYTE_W-1:0]         pat,
        input logic [8:0]                idx
    );
        engine_result_t res;
        int             xs, ys, lim_w, lim_h, col_x, row_y, addr;
        logic [BYTE_W-1:0] mask;
        res.rd_byte = '0;
        res.clip    = 1'b0;
        res.seq     = 0;
        case (op)
            FUNC_DRAW:
            begin
                xs    = int'(xv);
                ys    = int'(yv);
                lim_w = turns_cfg[0] ? PANEL_HEIGHT : PANEL_WIDTH;
                lim_h = turns_cfg[0] ? PANEL_WIDTH : PANEL_HEIGHT;
                if (xs < 0 || xs >= lim_w || ys < 0 || ys >= lim_h)
                    res.clip = 1'b1;
                else
                begin
                    case (turns_cfg)
                        ROT_QUARTER:
                        begin
                            col_x = ys;
                            row_y = PANEL_HEIGHT - 1 - xs;
                        end
                        ROT_HALF:
                        begin
                            col_x = PANEL_WIDTH - 1 - xs;
                            row_y = PANEL_HEIGHT - 1 - ys;
                        end
                        ROT_THREE_QUARTER:
                        begin
                            col_x = PANEL_WIDTH - 1 - ys;
                            row_y = xs;
                        end
                        default:
                        begin
                            col_x = xs;
                            row_y = ys;
                        end
                    endcase
                    addr = PANEL_WIDTH * (row_y / PAGE_BITS) + col_x;
                    mask = 8'h01 << (row_y % PAGE_BITS);
                    if (addr < STORE_DEPTH)
                    begin
                        last_drawn = addr;
                        case (col)
                            COLOUR_CLEAR:  pix_bytes[addr] = pix_bytes[addr] & ~mask;
                            COLOUR_SET:    pix_bytes[addr] = pix_bytes[addr] | mask;
                            COLOUR_TOGGLE: pix_bytes[addr] = pix_bytes[addr] ^ mask;
                            default: ;
                        endcase
                    end
                end
            end
            FUNC_FILL:
                foreach (pix_bytes[i])
                    pix_bytes[i] = pat;
            FUNC_READ:
                if (idx < STORE_DEPTH)
                    res.rd_byte = pix_bytes[idx];
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_sender)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Hold the request until accepted; leave start high when no gap follows.
    task automatic send_request(
        input logic [1:0]                op,
        input logic signed [COORD_W-1:0] xv,
        input logic signed [COORD_W-1:0] yv,
        input logic [1:0]                col,
        input logic [BYTE_W-1:0]         pat,
        input logic [8:0]                idx,
        input int                        gap
    );
        engine_result_t want;
        start        <= 1'b1;
        func         <= op;
        x_coord      <= xv;
        y_coord      <= yv;
        colour       <= col;
        fill_pattern <= pat;
        read_index   <= idx;
        do
            @(posedge clk);
        while (busy);
        want     = apply_request(op, xv, yv, col, pat, idx);
        want.seq = req_count;
        req_count++;
        pending_results.push_back(want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rotation(input logic [1:0] turns);
        cfg_valid <= 1'b1;
        rotation  <= turns;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        turns_cfg = turns;
    endtask

    always @(posedge clk)
    begin : result_check
        engine_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unrequested result read_byte=%h clipped=%b",
                                       read_byte, clipped));
            else
            begin
                want = pending_results.pop_front();
                if (read_byte !== want.rd_byte)
                    report_error($sformatf("request %0d read_byte %h, want %h",
                                           want.seq, read_byte, want.rd_byte));
                if (clipped !== want.clip)
                    report_error($sformatf("request %0d clipped %b, want %b",
                                           want.seq, clipped, want.clip));
            end
        end
    end

    // Store reads zero after reset, and past its end.
    task automatic test_after_reset();
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'(STORE_DEPTH - 1), pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'(STORE_DEPTH), pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'hFF, 9'h1FF, pick_gap());
    endtask

    task automatic test_draw_edges();
        send_request(FUNC_DRAW, 0, 0, COLOUR_SET, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 9'(PANEL_WIDTH - 1), 9'(PANEL_HEIGHT - 1), COLOUR_SET,
                     8'h00, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'(STORE_DEPTH - 1), pick_gap());
        send_request(FUNC_DRAW, 9'(PANEL_WIDTH - 1), 9'(PANEL_HEIGHT - 1), COLOUR_TOGGLE,
                     8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'(STORE_DEPTH - 1), pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 0, 0, COLOUR_CLEAR, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
    endtask

    task automatic test_clipping();
        send_request(FUNC_DRAW, -1, 0, COLOUR_SET, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 9'(PANEL_WIDTH), 0, COLOUR_SET, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 0, 9'(PANEL_HEIGHT), COLOUR_TOGGLE, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 0, -1, COLOUR_SET, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, -256, -256, COLOUR_SET, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_DRAW, 255, 255, COLOUR_CLEAR, 8'h00, 9'd0, pick_gap());
    endtask

    task automatic test_fill_and_noop();
        send_request(FUNC_FILL, 0, 0, COLOUR_KEEP, 8'hFF, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'(STORE_DEPTH), pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'd251, pick_gap());
        // no-op with every field driven high must change nothing
        send_request(FUNC_NOP, -1, -1, COLOUR_KEEP, 8'hFF, 9'h1FF, pick_gap());
        send_request(FUNC_FILL, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
        send_request(FUNC_READ, 0, 0, COLOUR_KEEP, 8'h00, 9'd0, pick_gap());
    endtask

    task automatic send_random_request();
        int                        sel, r, lim_w, lim_h;
        logic [1:0]                op;
        logic [1:0]                col;
        logic signed [COORD_W-1:0] xv, yv;
        logic [BYTE_W-1:0]         pat;
        logic [8:0]                idx;
        lim_w = turns_cfg[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        lim_h = turns_cfg[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        sel   = $urandom_range(0, 99);
        col   = 2'($urandom_range(0, 3));
        pat   = 8'($urandom_range(0, 255));
        xv    = 9'($urandom_range(0, 511));
        yv    = 9'($urandom_range(0, 511));
        idx   = 9'($urandom_range(0, 511));
        if (sel < 55)
        begin
            op = FUNC_DRAW;
            r  = $urandom_range(0, 99);
            if (r < 85)
            begin
                xv = 9'($urandom_range(0, lim_w - 1));
                yv = 9'($urandom_range(0, lim_h - 1));
            end
            else if (r < 93)
            begin
                // one step past an edge
                xv = $urandom_range(0, 1) ? 9'h1FF : 9'(lim_w);
                yv = 9'($urandom_range(0, lim_h - 1));
                if ($urandom_range(0, 1))
                begin
                    xv = 9'($urandom_range(0, lim_w - 1));
                    yv = $urandom_range(0, 1) ? 9'h1FF : 9'(lim_h);
                end
            end
        end
        else if (sel < 92)
        begin
            op = FUNC_READ;
            r  = $urandom_range(0, 99);
            if (r < 50)
                idx = 9'(last_drawn);
            else if (r < 90)
                idx = 9'($urandom_range(0, STORE_DEPTH - 1));
        end
        else if (sel < 95)
            op = FUNC_FILL;
        else
            op = FUNC_NOP;
        send_request(op, xv, yv, col, pat, idx, pick_gap());
    endtask

    // Every rotation in turn, then random ones.
    task automatic test_random_traffic();
        logic [1:0] turn_seq [4] = '{ROT_QUARTER, ROT_HALF, ROT_THREE_QUARTER, ROT_NONE};
        logic [1:0] turns;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            turns = (p < 4) ? turn_seq[p] : 2'($urandom_range(0, 3));
            write_rotation(turns);
            steady_sender = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) send_random_request();
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_rotation(ROT_NONE);
        test_after_reset();
        test_draw_edges();
        test_clipping();
        test_fill_and_noop();
        test_random_traffic();
        drain_results();
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mlcd_pkg.sv
rtl/core/mlcd_map.sv
rtl/core/mlcd_ram.sv
rtl/core/mono_lcd_framebuffer_pixel_engine.sv
bench/tb_top.sv
